// File: src/overwrite_oldest_byte_fifo_core_assert.svh
// Assertion macros for the overwriting byte FIFO.
// Included by the modules that check their own logic; no other dependencies.
`ifndef OVERWRITE_OLDEST_BYTE_FIFO_CORE_ASSERT_SVH
`define OVERWRITE_OLDEST_BYTE_FIFO_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property, sampled on clk and disabled while reset is asserted.
`define OBF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked property that also holds while reset is asserted.
`define OBF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OBF_ASSERT(lbl, prop, msg)
`define OBF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: src/obf_pkg.sv
// Shared types and constants for the overwriting byte FIFO.
// No dependencies; used by obf_ram and overwrite_oldest_byte_fifo_core.
package obf_pkg;

	// Default number of byte entries.
	localparam int DEPTH_DEFAULT = 4096;

	// Fixed field widths of the request and response words.
	localparam int OP_W     = 2;
	localparam int BYTE_W   = 8;
	localparam int SKIP_W   = 13;
	localparam int OFFS_W   = 12;
	localparam int FILL_W   = 13;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_SKIP  = 2'd2;
	localparam logic [OP_W-1:0] OP_PEEK  = 2'd3;

	// Byte returned when no stored byte is delivered.
	localparam logic [BYTE_W-1:0] NONE_BYTE = 8'hff;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [BYTE_W-1:0] write_byte;
		logic [SKIP_W-1:0] skip_count;
		logic [OFFS_W-1:0] peek_offset;
		logic              burst_last;
	} req_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              oldest_dropped;
		logic [FILL_W-1:0] fill_level;
		logic              burst_done;
	} rsp_word_t;

endpackage

// File: src/obf_ram.sv
// Byte storage for the overwriting FIFO: one write port, one read port.
// Read data is registered and updates only when a read is enabled. Uses obf_pkg.
module obf_ram #(
	parameter int DEPTH = obf_pkg::DEPTH_DEFAULT
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  logic [obf_pkg::BYTE_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	output logic [obf_pkg::BYTE_W-1:0] rd_data
);
	import obf_pkg::*;

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/overwrite_oldest_byte_fifo_core.sv
// Overwriting byte FIFO: a byte ring buffer with write, read, skip and peek operations,
// one request word in and one response word out. The buffer holds DEPTH bytes in a
// single memory with a registered read port; the read point, write point and fill count
// live in flip-flops and are updated in the cycle a request is accepted. Every request
// gives its response in the cycle after it is accepted, and a new request is taken
// every clock as long as the response register is empty or being taken in that cycle;
// the response fields are registered alongside the memory read. A write to a full
// buffer drops the oldest byte and flags it. A read of an empty buffer, a peek past the
// fill level, and any write or skip return 0xff with byte_valid low. A skip is clamped
// to the fill level. No clearing pass follows reset: only entries that hold written bytes
// are ever read. Depends on obf_pkg, obf_ram and the assertion header.
module overwrite_oldest_byte_fifo_core #(
	parameter int DEPTH = obf_pkg::DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  obf_pkg::req_word_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output obf_pkg::rsp_word_t  rsp
);
	import obf_pkg::*;

`include "overwrite_oldest_byte_fifo_core_assert.svh"

	// Pointer width, count width, and a compare width wide enough for the port fields.
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > SKIP_W) ? CW : SKIP_W;

	logic [PW-1:0] rp_q, wp_q;
	logic [CW-1:0] held_q;
	logic          rsp_valid_q;

	logic          byte_valid_s1;
	logic          dropped_s1;
	logic          ready_s1;
	logic [FILL_W-1:0] fill_s1;

	logic          accept;
	logic          full;
	logic [XW-1:0] held_x, skip_x, offs_x, skip_n;
	logic [CW-1:0] held_d, rp_step;
	logic [XW-1:0] held_dx;
	logic [PW-1:0] rp_d, wp_d, peek_addr;
	logic          mem_we, mem_re;
	logic [PW-1:0] rd_addr;
	logic          valid_d, dropped_d, ready_d;
	logic [BYTE_W-1:0] rd_data;

	// Add a step of at most DEPTH to a point below DEPTH, wrapping once.
	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [CW-1:0] s);
		logic [CW:0] sum;
		sum = (CW+1)'(p) + (CW+1)'(s);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[PW-1:0];
	endfunction

	// Handshake: a new word enters whenever the response register is free or draining.
	assign accept    = req_valid && req_ready;
	assign req_ready = !rsp_valid_q || rsp_ready;

	// Operands widened to a common compare width.
	assign held_x    = XW'(held_q);
	assign skip_x    = XW'(req.skip_count);
	assign offs_x    = XW'(req.peek_offset);
	assign skip_n    = (skip_x < held_x) ? skip_x : held_x;
	assign full      = (held_q == CW'(DEPTH));
	assign peek_addr = wrap_add(rp_q, offs_x[CW-1:0]);

	// Decode the operation into the next pointer and count values.
	always_comb begin
		held_d    = held_q;
		rp_step   = '0;
		wp_d      = wp_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		rd_addr   = rp_q;
		valid_d   = 1'b0;
		dropped_d = 1'b0;
		ready_d   = 1'b0;
		case (req.operation)
			OP_WRITE: begin
				mem_we  = 1'b1;
				wp_d    = wrap_add(wp_q, CW'(1));
				ready_d = req.burst_last;
				if (full) begin
					rp_step   = CW'(1);
					dropped_d = 1'b1;
				end else begin
					held_d = held_q + CW'(1);
				end
			end
			OP_READ: begin
				if (held_q != '0) begin
					mem_re  = 1'b1;
					valid_d = 1'b1;
					rp_step = CW'(1);
					held_d  = held_q - CW'(1);
				end
			end
			OP_SKIP: begin
				rp_step = skip_n[CW-1:0];
				held_d  = held_q - skip_n[CW-1:0];
			end
			OP_PEEK: begin
				if (offs_x < held_x) begin
					mem_re  = 1'b1;
					valid_d = 1'b1;
					rd_addr = peek_addr;
				end
			end
			default: begin
				held_d = held_q;
			end
		endcase
	end

	assign rp_d    = wrap_add(rp_q, rp_step);
	assign held_dx = XW'(held_d);

	// Pointer and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			wp_q   <= '0;
			held_q <= '0;
		end else if (accept) begin
			rp_q   <= rp_d;
			wp_q   <= wp_d;
			held_q <= held_d;
		end
	end

	// Response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response fields that travel alongside the memory read.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_valid_s1 <= valid_d;
			dropped_s1    <= dropped_d;
			ready_s1      <= ready_d;
			fill_s1       <= held_dx[FILL_W-1:0];
		end
	end

	obf_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (accept && mem_we),
		.wr_addr (wp_q),
		.wr_data (req.write_byte),
		.rd_en   (accept && mem_re),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Response word.
	assign rsp_valid          = rsp_valid_q;
	assign rsp.out_byte       = byte_valid_s1 ? rd_data : NONE_BYTE;
	assign rsp.byte_valid     = byte_valid_s1;
	assign rsp.oldest_dropped = dropped_s1;
	assign rsp.fill_level     = fill_s1;
	assign rsp.burst_done     = ready_s1;

	// The fill count never exceeds the buffer size.
	`OBF_ASSERT(a_held_bound, held_q <= CW'(DEPTH), "fill count above buffer size")
	// An empty buffer has its read and write points together.
	`OBF_ASSERT(a_empty_ptrs, (held_q == '0) |-> (rp_q == wp_q),
		"empty buffer with split points")
	// A write to a buffer that is not full grows the count by one.
	`OBF_ASSERT(a_write_grow,
		(accept && req.operation == OP_WRITE && !full) |=> (held_q == $past(held_q) + CW'(1)),
		"write did not grow count")
	// A drop is reported only with the buffer full.
	`OBF_ASSERT(a_drop_full,
		(rsp_valid && rsp.oldest_dropped) |-> (rsp.fill_level == FILL_W'(DEPTH)),
		"drop reported below full")
	// A response never both delivers a byte and reports a drop.
	`OBF_ASSERT(a_drop_excl, rsp_valid |-> !(rsp.byte_valid && rsp.oldest_dropped),
		"byte and drop in one response")

endmodule

// File: bench/tb_overwrite_oldest_byte_fifo_core.sv
// Self-checking testbench for overwrite_oldest_byte_fifo_core: random and directed ring
// buffer traffic with a scoreboard that predicts every response word.
// Depends on obf_pkg and the core module only.
`timescale 1ns / 1ps

module tb_overwrite_oldest_byte_fifo_core;
	import obf_pkg::*;

	localparam int DEPTH = DEPTH_DEFAULT;
	localparam int RANDOM_ITEMS = 1640;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 4000;

	// Scoreboard: keeps its own copy of the ring and queues the expected response words.
	class byte_ring_scoreboard;
		bit [BYTE_W-1:0] ring_bytes [DEPTH];
		int unsigned head_idx;
		int unsigned tail_idx;
		int unsigned held;
		rsp_word_t due_rsp_q [$];
		int unsigned mismatches;
		int unsigned op_counts [4];
		int unsigned drop_count;
		int unsigned peak_held;

		function void note_request(req_word_t w);
			rsp_word_t e;
			int unsigned n;
			e.out_byte = NONE_BYTE;
			e.byte_valid = 1'b0;
			e.oldest_dropped = 1'b0;
			e.burst_done = 1'b0;
			op_counts[w.operation]++;
			case (w.operation)
				OP_WRITE: begin
					// A full ring gives up its oldest byte before the store.
					if (held >= DEPTH) begin
						tail_idx = (tail_idx + 1) % DEPTH;
						held--;
						e.oldest_dropped = 1'b1;
						drop_count++;
					end
					ring_bytes[head_idx] = w.write_byte;
					head_idx = (head_idx + 1) % DEPTH;
					held++;
					e.burst_done = w.burst_last;
				end
				OP_READ: begin
					if (held > 0) begin
						e.out_byte = ring_bytes[tail_idx];
						e.byte_valid = 1'b1;
						tail_idx = (tail_idx + 1) % DEPTH;
						held--;
					end
				end
				OP_SKIP: begin
					// The count is clamped to what the ring holds.
					n = (w.skip_count < held) ? w.skip_count : held;
					tail_idx = (tail_idx + n) % DEPTH;
					held -= n;
				end
				default: begin
					if (w.peek_offset < held) begin
						e.out_byte = ring_bytes[(tail_idx + w.peek_offset) % DEPTH];
						e.byte_valid = 1'b1;
					end
				end
			endcase
			e.fill_level = held[FILL_W-1:0];
			if (held > peak_held)
				peak_held = held;
			due_rsp_q.push_back(e);
		endfunction

		task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
			mismatches++;
			$display("%0t mismatch on %0s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
		endtask

		task check_response(rsp_word_t got);
			rsp_word_t want;
			if (due_rsp_q.size() == 0) begin
				report_mismatch("unexpected response word", 16'(got.fill_level), 16'd0);
				return;
			end
			want = due_rsp_q.pop_front();
			if (got.out_byte !== want.out_byte)
				report_mismatch("out_byte", 16'(got.out_byte), 16'(want.out_byte));
			if (got.byte_valid !== want.byte_valid)
				report_mismatch("byte_valid", 16'(got.byte_valid), 16'(want.byte_valid));
			if (got.oldest_dropped !== want.oldest_dropped)
				report_mismatch("oldest_dropped", 16'(got.oldest_dropped),
					16'(want.oldest_dropped));
			if (got.fill_level !== want.fill_level)
				report_mismatch("fill_level", 16'(got.fill_level), 16'(want.fill_level));
			if (got.burst_done !== want.burst_done)
				report_mismatch("burst_done", 16'(got.burst_done), 16'(want.burst_done));
		endtask

		function int unsigned pending();
			return due_rsp_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_word_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_word_t rsp;

	byte_ring_scoreboard sb;
	logic calm = 1'b0;
	logic rsp_hold = 1'b0;
	int unsigned items_sent = 0;
	int unsigned quiet_cycles = 0;

	overwrite_oldest_byte_fifo_core #(
		.DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// 125 MHz clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Quiet stretches with no idling on either side alternate with busy ones.
	initial begin
		forever begin
			repeat ($urandom_range(150, 500)) @(posedge clk);
			calm = ($urandom_range(0, 3) == 0);
		end
	end

	// Monitor: every accepted word goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid === 1'b1 && rsp_ready)
				sb.check_response(rsp);
			if (req_valid && req_ready === 1'b1)
				sb.note_request(req);
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_overwrite_oldest_byte_fifo_core NOT OK");
			$finish;
		end
	end

	// Response side: random stalls, mostly short, plus one long hold-off on request.
	initial begin
		int stall;
		int r;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_hold) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_hold = 1'b0;
				rsp_ready <= 1'b1;
			end else if (stall > 0) begin
				rsp_ready <= 1'b0;
				stall--;
			end else if (calm) begin
				rsp_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					rsp_ready <= 1'b1;
				end else begin
					rsp_ready <= 1'b0;
					stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 60);
				end
			end
		end
	end

	// Idle cycles before the next request word: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Request word with every field random; callers override the ones that matter.
	function automatic req_word_t make_word(logic [OP_W-1:0] op);
		req_word_t w;
		w.operation = op;
		w.write_byte = BYTE_W'($urandom);
		w.skip_count = SKIP_W'($urandom);
		w.peek_offset = OFFS_W'($urandom);
		w.burst_last = 1'($urandom);
		return w;
	endfunction

	// Offers one request word and returns at the edge where it is taken.
	task automatic send_word(input req_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!(req_valid && req_ready));
		items_sent++;
	endtask

	task automatic do_write(input logic [BYTE_W-1:0] b, input logic last);
		req_word_t w;
		w = make_word(OP_WRITE);
		w.write_byte = b;
		w.burst_last = last;
		send_word(w);
	endtask

	task automatic do_read();
		send_word(make_word(OP_READ));
	endtask

	task automatic do_skip(input logic [SKIP_W-1:0] n);
		req_word_t w;
		w = make_word(OP_SKIP);
		w.skip_count = n;
		send_word(w);
	endtask

	task automatic do_peek(input logic [OFFS_W-1:0] offs);
		req_word_t w;
		w = make_word(OP_PEEK);
		w.peek_offset = offs;
		send_word(w);
	endtask

	// Stops offering words until every expected response word has come back.
	task automatic wait_all_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Main sequence: reset, directed cases, random traffic, then a short mixed tail.
	initial begin
		int i;
		int len;
		int pick;
		int r;
		int tmp;
		int unsigned rand_end;
		bit did_hold;
		bit did_drain;
		did_hold = 1'b0;
		did_drain = 1'b0;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty ring: read, peek and skips all come back with no byte.
		do_read();
		do_peek('0);
		do_skip('0);
		do_skip(SKIP_W'(DEPTH));
		// Extreme bytes, the run-end flag on the last of a run, peeks inside and past the fill.
		do_write(8'h00, 1'b0);
		do_write(8'hff, 1'b0);
		do_write(8'h5a, 1'b1);
		do_peek(12'd0);
		do_peek(12'd2);
		do_peek(12'd3);
		do_peek({OFFS_W{1'b1}});
		do_read();
		do_read();
		// Skip far beyond the fill level, then read the empty ring.
		do_skip({SKIP_W{1'b1}});
		do_read();
		do_write(8'h01, 1'b0);
		do_write(8'h80, 1'b0);
		do_write(8'h7f, 1'b1);
		do_skip(13'd1);
		do_peek(12'd1);
		do_read();
		do_read();
		do_read();

		// Random runs of writes, reads, peeks and skips, with some raw noise words.
		rand_end = items_sent + RANDOM_ITEMS;
		while (items_sent < rand_end) begin
			if (!did_hold && items_sent > rand_end - 1150) begin
				// Response side holds off while requests keep coming.
				rsp_hold = 1'b1;
				did_hold = 1'b1;
			end
			if (!did_drain && items_sent > rand_end - 650) begin
				wait_all_results();
				did_drain = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 12);
				for (i = 0; i < len; i++)
					do_write(BYTE_W'($urandom),
						(i == len - 1) ? 1'b1 : ($urandom_range(0, 15) == 0));
			end else if (pick < 65) begin
				repeat ($urandom_range(1, 8)) do_read();
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 6)) begin
					r = $urandom_range(0, 99);
					if (r < 70 && sb.held > 0) begin
						tmp = $urandom_range(0, sb.held - 1);
					end else if (r < 85) begin
						tmp = sb.held + $urandom_range(0, 8);
						if (tmp > DEPTH - 1)
							tmp = DEPTH - 1;
					end else begin
						tmp = $urandom_range(0, DEPTH - 1);
					end
					do_peek(OFFS_W'(tmp));
				end
			end else if (pick < 90) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					tmp = $urandom_range(0, sb.held);
				else if (r < 85)
					tmp = sb.held + $urandom_range(1, 20);
				else if (r < 92)
					tmp = DEPTH;
				else
					tmp = $urandom_range(0, (1 << SKIP_W) - 1);
				do_skip(SKIP_W'(tmp));
			end else begin
				send_word(make_word(OP_W'($urandom_range(0, 3))));
			end
		end

		// Mixed traffic with peeks at random offsets and at the top offset.
		wait_all_results();
		repeat (80) begin
			case ($urandom_range(0, 3))
				0: do_write(BYTE_W'($urandom), 1'($urandom));
				1: do_read();
				2: do_peek(OFFS_W'($urandom));
				default: do_peek(OFFS_W'(DEPTH - 1));
			endcase
		end
		do_skip(SKIP_W'(DEPTH));
		do_read();
		do_peek('0);
		do_write(8'hc3, 1'b1);
		do_peek('0);

		// Let the last words drain and give the core time to show anything stray.
		wait_all_results();
		repeat (8) @(posedge clk);
		$display("Covered %0d writes, %0d reads, %0d skips and %0d peeks.",
			sb.op_counts[OP_WRITE], sb.op_counts[OP_READ], sb.op_counts[OP_SKIP],
			sb.op_counts[OP_PEEK]);
		$display("Saw %0d overwrites of the oldest byte; peak fill %0d of %0d, %0d mismatches.",
			sb.drop_count, sb.peak_held, DEPTH, sb.mismatches);
		if (sb.mismatches == 0)
			$display("tb_overwrite_oldest_byte_fifo_core OK");
		else
			$display("tb_overwrite_oldest_byte_fifo_core NOT OK");
		$finish;
	end

endmodule

// File: overwrite_oldest_byte_fifo_core.f
+incdir+src
src/obf_pkg.sv
src/obf_ram.sv
src/overwrite_oldest_byte_fifo_core.sv
bench/tb_overwrite_oldest_byte_fifo_core.sv
